FILE: design/laob_pkg.sv
// ----------------------------------------------------------------------------
// laob_pkg: shared types and constants of the look-at orientation basis
// Fixed-point widths, normaliser pipeline depths, register indexes and the
// result record that travels to the output buffer.
// ----------------------------------------------------------------------------
package laob_pkg;

  // Field widths and fixed-point formats.
  localparam int IN_W        = 32;
  localparam int Q_W         = 16;
  localparam int Q_FRAC      = 14;
  localparam int Q14_ONE     = 16384;

  // Normalised magnitudes lie in [2^29, 2^30).
  localparam int NORM_LO_BIT = 29;
  localparam int MAG_W       = 30;
  localparam int NORM_LO     = 1 << NORM_LO_BIT;

  // Square root and divider widths.
  localparam int RT_W        = 2 * MAG_W + 2;
  localparam int LEN_W       = RT_W / 2;
  localparam int NUM_W       = MAG_W + Q_FRAC + 1;
  localparam int DV_W        = NUM_W + 1;

  // Vector widths in the datapath.
  localparam int DIFF_W      = IN_W + 1;
  localparam int UP_W        = 2 * (MAG_W + 1) + 1;

  // Normaliser pipeline: shift steps, square-root steps, quotient bits.
  localparam int RSHIFT_STEPS   = 6;
  localparam int LSHIFT_STEPS   = 5;
  localparam int SHIFT_STEPS    = RSHIFT_STEPS + LSHIFT_STEPS;
  localparam int ISQRT_STEPS    = LEN_W;
  localparam int DIV_STEPS      = 15;
  localparam int NORM_SCALE_LAT = 1 + SHIFT_STEPS;
  localparam int NORM_Q_LAT     = NORM_SCALE_LAT + 2 + ISQRT_STEPS + 1 + DIV_STEPS + 1;

  // Item kinds.
  localparam logic KIND_POINT = 1'b0;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CAM_POS_X = 2'd0,
    REG_CAM_POS_Y = 2'd1,
    REG_CAM_POS_Z = 2'd2
  } cfg_reg_t;

  // One result item.
  typedef struct packed {
    logic signed [Q_W-1:0] right_x;
    logic signed [Q_W-1:0] right_y;
    logic signed [Q_W-1:0] right_z;
    logic signed [Q_W-1:0] up_x;
    logic signed [Q_W-1:0] up_y;
    logic signed [Q_W-1:0] up_z;
    logic signed [Q_W-1:0] fwd_x;
    logic signed [Q_W-1:0] fwd_y;
    logic signed [Q_W-1:0] fwd_z;
    logic                  fallback_used;
    logic                  zero_length;
  } result_t;

endpackage

FILE: design/laob_delay.sv
// ----------------------------------------------------------------------------
// laob_delay: stallable delay line
// Carries side data alongside the pipeline for a fixed number of stages.
// ----------------------------------------------------------------------------
module laob_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_r [N];

  // The whole line advances together with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign q_o = line_r[N-1];

endmodule

FILE: design/laob_norm3.sv
// ----------------------------------------------------------------------------
// laob_norm3: pipelined three-component vector normaliser
// Scales the magnitudes so the largest lies in [2^29, 2^30), takes the
// integer square root of the sum of squares one bit per stage and divides
// each component by the length one quotient bit per stage (Q2.14 result).
// ----------------------------------------------------------------------------
module laob_norm3
  import laob_pkg::*;
#(
  parameter int VW = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [VW-1:0]  vec_i    [3],
  output logic signed [MAG_W:0] scaled_o [3],
  output logic                  zero_o,
  output logic signed [Q_W-1:0] quant_o  [3]
);

  localparam int MW = (VW > MAG_W) ? VW : MAG_W;

  logic [VW-1:0]            abs_mag [3];
  logic [VW-1:0]            abs_max;
  logic [MW-1:0]            sh_mag_r [SHIFT_STEPS+1][3];
  logic [MW-1:0]            sh_mx_r  [SHIFT_STEPS+1];
  logic [2:0]               neg_r;
  logic                     zero_r;
  logic [2:0]               neg_s;
  logic                     zero_s;
  logic [MAG_W-1:0]         mag_s [3];
  logic [2*MAG_W-1:0]       sq_r [3];
  logic [RT_W-1:0]          rt_v_r [ISQRT_STEPS+1];
  logic [RT_W-1:0]          rt_q_r [ISQRT_STEPS+1];
  logic [3*MAG_W-1:0]       mag_d;
  logic [LEN_W-1:0]         len;
  logic [NUM_W-1:0]         dv_rem_r [DIV_STEPS+1][3];
  logic [LEN_W-1:0]         dv_len_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]     dv_q_r   [DIV_STEPS+1][3];
  logic [2:0]               neg_q;
  logic                     zero_q;
  logic signed [Q_W-1:0]    quant_r [3];

  // Magnitudes, signs and the largest magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_mag[i] = vec_i[i][VW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    abs_max = abs_mag[0];
    if (abs_mag[1] > abs_max) begin
      abs_max = abs_mag[1];
    end
    if (abs_mag[2] > abs_max) begin
      abs_max = abs_mag[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sh_mag_r[0][i] <= MW'(abs_mag[i]);
        neg_r[i]       <= vec_i[i][VW-1];
      end
      sh_mx_r[0] <= MW'(abs_max);
      zero_r     <= (abs_max == '0);
    end
  end

  // Binary normalising shift: right steps truncate, left steps are exact.
  for (genvar k = 0; k < SHIFT_STEPS; k++) begin : g_shift
    localparam bit SH_RIGHT = (k < RSHIFT_STEPS);
    localparam int SH_EXP   = SH_RIGHT ? (RSHIFT_STEPS - 1 - k) : (SHIFT_STEPS - 1 - k);
    localparam int SH_AMT   = 1 << SH_EXP;

    logic do_sh;

    always_comb begin
      if (SH_RIGHT) begin
        do_sh = (sh_mx_r[k] >> (NORM_LO_BIT + SH_AMT)) != '0;
      end else begin
        do_sh = (sh_mx_r[k] >> (NORM_LO_BIT + 1 - SH_AMT)) == '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!do_sh) begin
          sh_mx_r[k+1] <= sh_mx_r[k];
          for (int i = 0; i < 3; i++) begin
            sh_mag_r[k+1][i] <= sh_mag_r[k][i];
          end
        end else if (SH_RIGHT) begin
          sh_mx_r[k+1] <= sh_mx_r[k] >> SH_AMT;
          for (int i = 0; i < 3; i++) begin
            sh_mag_r[k+1][i] <= sh_mag_r[k][i] >> SH_AMT;
          end
        end else begin
          sh_mx_r[k+1] <= sh_mx_r[k] << SH_AMT;
          for (int i = 0; i < 3; i++) begin
            sh_mag_r[k+1][i] <= sh_mag_r[k][i] << SH_AMT;
          end
        end
      end
    end
  end

  laob_delay #(.W(4), .N(SHIFT_STEPS)) u_sgn_dly (
    .clk (clk),
    .en  (en),
    .d_i ({zero_r, neg_r}),
    .q_o ({zero_s, neg_s})
  );

  // Scaled vector with signs restored.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_s[i]    = sh_mag_r[SHIFT_STEPS][i][MAG_W-1:0];
      scaled_o[i] = neg_s[i] ? -$signed({1'b0, mag_s[i]}) : $signed({1'b0, mag_s[i]});
    end
  end

  assign zero_o = zero_s;

  // Squares, then their sum seeds the square root.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mag_s[i] * mag_s[i];
      end
      rt_v_r[0] <= RT_W'(sq_r[0]) + RT_W'(sq_r[1]) + RT_W'(sq_r[2]);
      rt_q_r[0] <= '0;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_rt
    localparam logic [RT_W-1:0] RT_BIT = RT_W'(1) << (2 * (ISQRT_STEPS - 1 - k));

    logic [RT_W:0] trial;

    assign trial = {1'b0, rt_q_r[k]} + {1'b0, RT_BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rt_v_r[k]} >= trial) begin
          rt_v_r[k+1] <= rt_v_r[k] - trial[RT_W-1:0];
          rt_q_r[k+1] <= (rt_q_r[k] >> 1) + RT_BIT;
        end else begin
          rt_v_r[k+1] <= rt_v_r[k];
          rt_q_r[k+1] <= rt_q_r[k] >> 1;
        end
      end
    end
  end

  laob_delay #(.W(3*MAG_W), .N(2 + ISQRT_STEPS)) u_mag_dly (
    .clk (clk),
    .en  (en),
    .d_i ({mag_s[2], mag_s[1], mag_s[0]}),
    .q_o (mag_d)
  );

  assign len = rt_q_r[ISQRT_STEPS][LEN_W-1:0];

  // Rounded dividends: component times one plus half the length.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= NUM_W'({mag_d[i*MAG_W +: MAG_W], {Q_FRAC{1'b0}}})
                        + NUM_W'(len >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0] <= len;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int DK = DIV_STEPS - 1 - j;

    logic [DV_W-1:0] dsh;
    logic [2:0]      take;

    always_comb begin
      dsh = DV_W'(dv_len_r[j]) << DK;
      for (int i = 0; i < 3; i++) begin
        take[i] = {1'b0, dv_rem_r[j][i]} >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= take[i] ? (dv_rem_r[j][i] - dsh[NUM_W-1:0]) : dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= dv_q_r[j][i] | (DIV_STEPS'(take[i]) << DK);
        end
        dv_len_r[j+1] <= dv_len_r[j];
      end
    end
  end

  laob_delay #(.W(4), .N(2 + ISQRT_STEPS + 1 + DIV_STEPS)) u_sgn_q_dly (
    .clk (clk),
    .en  (en),
    .d_i ({zero_s, neg_s}),
    .q_o ({zero_q, neg_q})
  );

  // Saturate to one, apply the sign, and clear a zero-length vector.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_q) begin
          quant_r[i] <= '0;
        end else if (dv_q_r[DIV_STEPS][i] > DIV_STEPS'(Q14_ONE)) begin
          quant_r[i] <= neg_q[i] ? -Q_W'(Q14_ONE) : Q_W'(Q14_ONE);
        end else if (neg_q[i]) begin
          quant_r[i] <= -$signed(Q_W'(dv_q_r[DIV_STEPS][i]));
        end else begin
          quant_r[i] <= $signed(Q_W'(dv_q_r[DIV_STEPS][i]));
        end
      end
    end
  end

  assign quant_o = quant_r;

endmodule

FILE: design/look_at_orientation_basis.sv
// An input flows through the fixed-depth pipeline of three vector normalisers
// (31 square-root stages and 15 divider stages each); a waiting result transfers
// when out_ready is high. The block takes one item per cycle while the output
// buffer has a free entry, and stalls the whole pipeline when it is full.
// A two-entry output buffer keeps inputs flowing while one result waits.
// Reset clears the valid bits, the output buffer and the camera position to zero.
// ----------------------------------------------------------------------------
// look_at_orientation_basis: orthonormal camera basis from a look-at vector
// Forward is the normalised camera position minus the look point (or the given
// direction), right the normalised cross of world up with forward (with a
// vertical fallback), up the normalised cross of forward with right; all in Q2.14.
// ----------------------------------------------------------------------------
module look_at_orientation_basis
  import laob_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [IN_W-1:0]       cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic signed [IN_W-1:0] in_vec_x,
  input  logic signed [IN_W-1:0] in_vec_y,
  input  logic signed [IN_W-1:0] in_vec_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [Q_W-1:0] out_right_x,
  output logic signed [Q_W-1:0] out_right_y,
  output logic signed [Q_W-1:0] out_right_z,
  output logic signed [Q_W-1:0] out_up_x,
  output logic signed [Q_W-1:0] out_up_y,
  output logic signed [Q_W-1:0] out_up_z,
  output logic signed [Q_W-1:0] out_fwd_x,
  output logic signed [Q_W-1:0] out_fwd_y,
  output logic signed [Q_W-1:0] out_fwd_z,
  output logic                  out_fallback_used,
  output logic                  out_zero_length
);

  localparam int PIPE_LAT = 1 + 2 * NORM_SCALE_LAT + 2 + NORM_Q_LAT;

  logic signed [IN_W-1:0]   cam_x_r;
  logic signed [IN_W-1:0]   cam_y_r;
  logic signed [IN_W-1:0]   cam_z_r;
  logic                     en;
  logic [PIPE_LAT-1:0]      vld_r;
  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [MAG_W:0]    f_s [3];
  logic                     f_zero;
  logic signed [Q_W-1:0]    f_q [3];
  logic                     fb;
  logic signed [MAG_W:0]    r_in [3];
  logic signed [MAG_W:0]    rs_s [3];
  logic                     rs_zero;
  logic signed [Q_W-1:0]    r_q [3];
  logic [3*(MAG_W+1)-1:0]   f_d;
  logic signed [MAG_W:0]    fd [3];
  logic signed [2*MAG_W+1:0] p_r [4];
  logic signed [UP_W-1:0]   u_r [3];
  logic signed [MAG_W:0]    us_s [3];
  logic                     us_zero;
  logic signed [Q_W-1:0]    u_q [3];
  logic [3*Q_W-1:0]         rq_d;
  logic [3*Q_W-1:0]         fq_d;
  logic                     fb_d;
  logic                     zero_d;
  result_t                  res;
  result_t                  head_r;
  result_t                  spare_r;
  logic [1:0]               cnt_r;
  logic                     push;
  logic                     pop;

  // Camera position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAM_POS_X: cam_x_r <= cfg_data;
        REG_CAM_POS_Y: cam_y_r <= cfg_data;
        REG_CAM_POS_Z: cam_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output buffer has a free entry.
  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // Forward difference at full width.
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_kind == KIND_POINT) begin
        d_r[0] <= DIFF_W'(cam_x_r) - DIFF_W'(in_vec_x);
        d_r[1] <= DIFF_W'(cam_y_r) - DIFF_W'(in_vec_y);
        d_r[2] <= DIFF_W'(cam_z_r) - DIFF_W'(in_vec_z);
      end else begin
        d_r[0] <= DIFF_W'(in_vec_x);
        d_r[1] <= DIFF_W'(in_vec_y);
        d_r[2] <= DIFF_W'(in_vec_z);
      end
    end
  end

  laob_norm3 #(.VW(DIFF_W)) u_fwd_norm (
    .clk      (clk),
    .en       (en),
    .vec_i    (d_r),
    .scaled_o (f_s),
    .zero_o   (f_zero),
    .quant_o  (f_q)
  );

  // Right from world up cross forward, or the vertical fallback.
  always_comb begin
    fb = (f_s[0] == '0) && (f_s[2] == '0);
    if (fb) begin
      r_in[0] = (f_s[1] > 0) ? (MAG_W+1)'(NORM_LO) : (MAG_W+1)'(-NORM_LO);
      r_in[2] = '0;
    end else begin
      r_in[0] = f_s[2];
      r_in[2] = -f_s[0];
    end
    r_in[1] = '0;
  end

  laob_norm3 #(.VW(MAG_W+1)) u_right_norm (
    .clk      (clk),
    .en       (en),
    .vec_i    (r_in),
    .scaled_o (rs_s),
    .zero_o   (rs_zero),
    .quant_o  (r_q)
  );

  laob_delay #(.W(3*(MAG_W+1)), .N(NORM_SCALE_LAT)) u_f_dly (
    .clk (clk),
    .en  (en),
    .d_i ({f_s[2], f_s[1], f_s[0]}),
    .q_o (f_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fd[i] = $signed(f_d[i*(MAG_W+1) +: (MAG_W+1)]);
    end
  end

  // Up = forward cross right; right has no y component. Products first.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= fd[1] * rs_s[2];
      p_r[1] <= fd[2] * rs_s[0];
      p_r[2] <= fd[0] * rs_s[2];
      p_r[3] <= fd[1] * rs_s[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= UP_W'(p_r[0]);
      u_r[1] <= UP_W'(p_r[1]) - UP_W'(p_r[2]);
      u_r[2] <= -UP_W'(p_r[3]);
    end
  end

  laob_norm3 #(.VW(UP_W)) u_up_norm (
    .clk      (clk),
    .en       (en),
    .vec_i    (u_r),
    .scaled_o (us_s),
    .zero_o   (us_zero),
    .quant_o  (u_q)
  );

  // Align the right, forward and flag results with the up result.
  laob_delay #(.W(3*Q_W), .N(NORM_SCALE_LAT + 2)) u_rq_dly (
    .clk (clk),
    .en  (en),
    .d_i ({r_q[2], r_q[1], r_q[0]}),
    .q_o (rq_d)
  );

  laob_delay #(.W(3*Q_W), .N(2 * NORM_SCALE_LAT + 2)) u_fq_dly (
    .clk (clk),
    .en  (en),
    .d_i ({f_q[2], f_q[1], f_q[0]}),
    .q_o (fq_d)
  );

  laob_delay #(.W(2), .N(NORM_SCALE_LAT + 2 + NORM_Q_LAT)) u_flag_dly (
    .clk (clk),
    .en  (en),
    .d_i ({fb & ~f_zero, f_zero}),
    .q_o ({fb_d, zero_d})
  );

  // Result record; a zero-length forward clears right and up as well.
  always_comb begin
    res.right_x       = zero_d ? '0 : $signed(rq_d[0*Q_W +: Q_W]);
    res.right_y       = zero_d ? '0 : $signed(rq_d[1*Q_W +: Q_W]);
    res.right_z       = zero_d ? '0 : $signed(rq_d[2*Q_W +: Q_W]);
    res.up_x          = zero_d ? '0 : u_q[0];
    res.up_y          = zero_d ? '0 : u_q[1];
    res.up_z          = zero_d ? '0 : u_q[2];
    res.fwd_x         = $signed(fq_d[0*Q_W +: Q_W]);
    res.fwd_y         = $signed(fq_d[1*Q_W +: Q_W]);
    res.fwd_z         = $signed(fq_d[2*Q_W +: Q_W]);
    res.fallback_used = fb_d;
    res.zero_length   = zero_d;
  end

  // Two-entry output buffer.
  assign push = vld_r[PIPE_LAT-1] & en;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))) begin
      head_r <= res;
    end else if (pop && (cnt_r == 2'd2)) begin
      head_r <= spare_r;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      spare_r <= res;
    end
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_right_x       = head_r.right_x;
  assign out_right_y       = head_r.right_y;
  assign out_right_z       = head_r.right_z;
  assign out_up_x          = head_r.up_x;
  assign out_up_y          = head_r.up_y;
  assign out_up_z          = head_r.up_z;
  assign out_fwd_x         = head_r.fwd_x;
  assign out_fwd_y         = head_r.fwd_y;
  assign out_fwd_z         = head_r.fwd_z;
  assign out_fallback_used = head_r.fallback_used;
  assign out_zero_length   = head_r.zero_length;

endmodule

FILE: design/laob_checker.sv
// ----------------------------------------------------------------------------
// laob_checker: port-level checks of the look-at orientation basis
// Watches the result channel for stalled transfers, for the special cases of a
// zero-length forward and a vertical forward, for a flat right axis and for reset.
// ----------------------------------------------------------------------------
module laob_checker
  import laob_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [1:0]            cfg_index,
  input logic [IN_W-1:0]       cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_kind,
  input logic signed [IN_W-1:0] in_vec_x,
  input logic signed [IN_W-1:0] in_vec_y,
  input logic signed [IN_W-1:0] in_vec_z,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [Q_W-1:0] out_right_x,
  input logic signed [Q_W-1:0] out_right_y,
  input logic signed [Q_W-1:0] out_right_z,
  input logic signed [Q_W-1:0] out_up_x,
  input logic signed [Q_W-1:0] out_up_y,
  input logic signed [Q_W-1:0] out_up_z,
  input logic signed [Q_W-1:0] out_fwd_x,
  input logic signed [Q_W-1:0] out_fwd_y,
  input logic signed [Q_W-1:0] out_fwd_z,
  input logic                  out_fallback_used,
  input logic                  out_zero_length
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_right_x, out_right_y, out_right_z, out_up_x, out_up_y, out_up_z,
               out_fwd_x, out_fwd_y, out_fwd_z, out_fallback_used, out_zero_length}))
    else $error("result changed while stalled");

  // A zero-length forward gives an all-zero basis.
  a_zero_basis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> !out_fallback_used &&
      out_right_x == 0 && out_right_y == 0 && out_right_z == 0 &&
      out_up_x == 0 && out_up_y == 0 && out_up_z == 0 &&
      out_fwd_x == 0 && out_fwd_y == 0 && out_fwd_z == 0)
    else $error("zero-length result with a non-zero basis");

  // A vertical forward gives right along x and up along minus z.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fallback_used |->
      (out_right_x == Q_W'(Q14_ONE) || out_right_x == -Q_W'(Q14_ONE)) &&
      out_right_y == 0 && out_right_z == 0 &&
      out_up_x == 0 && out_up_y == 0 && out_up_z == -Q_W'(Q14_ONE))
    else $error("fallback basis is wrong");

  // Right always lies in the horizontal plane.
  a_right_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_right_y == 0)
    else $error("right axis has a vertical component");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind look_at_orientation_basis laob_checker u_laob_checker (.*);

FILE: bench/look_at_orientation_basis_tb.sv
// ----------------------------------------------------------------------------
// look_at_orientation_basis_tb: self-checking bench for the look-at basis
// Streams look points and directions through the block under several camera
// positions, with random gaps on both channels. Each result is predicted
// independently in fixed point and compared field by field, in order.
// ----------------------------------------------------------------------------
module look_at_orientation_basis_tb;
  import laob_pkg::*;

  localparam logic KIND_DIRECTION = ~KIND_POINT;
  localparam int   LATENCY        = 90;

  typedef struct {
    logic                   kind;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } look_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [IN_W-1:0]        cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_kind = 1'b0;
  logic signed [IN_W-1:0] in_vec_x = '0;
  logic signed [IN_W-1:0] in_vec_y = '0;
  logic signed [IN_W-1:0] in_vec_z = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  result_t                got;

  look_item_t             pending_items[$];
  result_t                expected_bases[$];
  logic signed [IN_W-1:0] cam_x = '0, cam_y = '0, cam_z = '0;
  int                     n_issued = 0, n_taken = 0, n_errors = 0;
  int                     in_gap = 0, out_gap = 0;
  bit                     in_burst = 0, out_burst = 0;

  look_at_orientation_basis dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_kind, .in_vec_x, .in_vec_y, .in_vec_z,
    .out_valid, .out_ready,
    .out_right_x(got.right_x), .out_right_y(got.right_y), .out_right_z(got.right_z),
    .out_up_x(got.up_x), .out_up_y(got.up_y), .out_up_z(got.up_z),
    .out_fwd_x(got.fwd_x), .out_fwd_y(got.fwd_y), .out_fwd_z(got.fwd_z),
    .out_fallback_used(got.fallback_used), .out_zero_length(got.zero_length)
  );

  always #5 clk = ~clk;

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector so its largest magnitude lies in [2^29, 2^30) and
  // returns the scaled vector and its rounded, saturated Q2.14 unit vector.
  function automatic bit unit_vector(input longint vx, vy, vz,
                                     output longint sx, sy, sz,
                                     output logic signed [Q_W-1:0] qx, qy, qz);
    longint      v[3], s[3];
    logic [63:0] m[3], mx, sum, len, r;
    logic signed [Q_W-1:0] q[3];
    v[0] = vx; v[1] = vy; v[2] = vz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    sx = 0; sy = 0; sz = 0; qx = 0; qy = 0; qz = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      r = (m[i] * Q14_ONE + len / 2) / len;
      if (r > Q14_ONE) r = Q14_ONE;
      s[i] = (v[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
      q[i] = (v[i] < 0) ? -r[Q_W-1:0] : r[Q_W-1:0];
    end
    sx = s[0]; sy = s[1]; sz = s[2];
    qx = q[0]; qy = q[1]; qz = q[2];
    return 1;
  endfunction

  // Expected basis for one look point or direction under the current camera.
  function automatic result_t camera_basis(input look_item_t it);
    result_t res;
    longint  dx, dy, dz, fx, fy, fz, rx, ry, rz, sx, sy, sz, ux, uy, uz;
    res = '0;
    dx = it.x; dy = it.y; dz = it.z;
    if (it.kind == KIND_POINT) begin
      dx = longint'(cam_x) - dx;
      dy = longint'(cam_y) - dy;
      dz = longint'(cam_z) - dz;
    end
    if (!unit_vector(dx, dy, dz, fx, fy, fz, res.fwd_x, res.fwd_y, res.fwd_z)) begin
      res.zero_length = 1'b1;
      return res;
    end
    if (fx == 0 && fz == 0) begin
      res.fallback_used = 1'b1;
      rx = (fy > 0) ? NORM_LO : -NORM_LO;
      ry = 0;
      rz = 0;
    end else begin
      rx = fz;
      ry = 0;
      rz = -fx;
    end
    void'(unit_vector(rx, ry, rz, sx, sy, sz, res.right_x, res.right_y, res.right_z));
    ux = fy * sz - fz * sy;
    uy = fz * sx - fx * sz;
    uz = fx * sy - fy * sx;
    void'(unit_vector(ux, uy, uz, rx, ry, rz, res.up_x, res.up_y, res.up_z));
    return res;
  endfunction

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Input driver: presents the next pending item once the last one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || n_taken == n_issued)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        look_item_t it;
        it = pending_items.pop_front();
        in_kind  <= it.kind;
        in_vec_x <= it.x;
        in_vec_y <= it.y;
        in_vec_z <= it.z;
        in_valid <= 1'b1;
        n_issued <= n_issued + 1;
        if ($urandom_range(0, 49) == 0) in_burst = ~in_burst;
        in_gap <= in_burst ? 0 : random_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Each input transfer adds its predicted basis to the store.
  always @(posedge clk) begin
    look_item_t it;
    if (rst_n && in_valid && in_ready) begin
      it.kind = in_kind; it.x = in_vec_x; it.y = in_vec_y; it.z = in_vec_z;
      expected_bases.push_back(camera_basis(it));
      n_taken <= n_taken + 1;
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
        out_gap <= out_burst ? 0 : random_gap();
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [Q_W-1:0] exp_v,
                             input logic [Q_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      n_errors++;
    end
  endtask

  // Result monitor: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bases.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        n_errors++;
      end else begin
        e = expected_bases.pop_front();
        check_field("right_x", e.right_x, got.right_x);
        check_field("right_y", e.right_y, got.right_y);
        check_field("right_z", e.right_z, got.right_z);
        check_field("up_x", e.up_x, got.up_x);
        check_field("up_y", e.up_y, got.up_y);
        check_field("up_z", e.up_z, got.up_z);
        check_field("fwd_x", e.fwd_x, got.fwd_x);
        check_field("fwd_y", e.fwd_y, got.fwd_y);
        check_field("fwd_z", e.fwd_z, got.fwd_z);
        check_field("fallback_used", e.fallback_used, got.fallback_used);
        check_field("zero_length", e.zero_length, got.zero_length);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic signed [IN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CAM_POS_X: cam_x = val;
      REG_CAM_POS_Y: cam_y = val;
      default:       cam_z = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(input logic signed [IN_W-1:0] x, y, z);
    write_reg(REG_CAM_POS_X, x);
    write_reg(REG_CAM_POS_Y, y);
    write_reg(REG_CAM_POS_Z, z);
  endtask

  task automatic add_item(input logic kind, input logic signed [IN_W-1:0] x, y, z);
    look_item_t it;
    it.kind = kind; it.x = x; it.y = y; it.z = z;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [IN_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 8) - 4;
      1:       return $signed($urandom_range(0, 2047)) - 1024;
      2:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Random items: mostly general vectors, with vertical and degenerate ones mixed in.
  task automatic add_random_items(input int count);
    logic kind;
    logic signed [IN_W-1:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 1);
      x = random_coord(); y = random_coord(); z = random_coord();
      case ($urandom_range(0, 9))
        0: begin
          x = (kind == KIND_POINT) ? cam_x : 0;
          z = (kind == KIND_POINT) ? cam_z : 0;
        end
        1: begin
          x = (kind == KIND_POINT) ? cam_x : 0;
          y = (kind == KIND_POINT) ? cam_y : 0;
          z = (kind == KIND_POINT) ? cam_z : 0;
        end
        default: ;
      endcase
      add_item(kind, x, y, z);
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_bases.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Stimulus: one directed phase, then random phases under several cameras.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero length, vertical fallbacks, extremes, tiny vectors.
    add_item(KIND_DIRECTION, 0, 0, 0);
    add_item(KIND_POINT, 0, 0, 0);
    add_item(KIND_DIRECTION, 0, 1, 0);
    add_item(KIND_DIRECTION, 0, -1, 0);
    add_item(KIND_POINT, 0, 32'sh7FFFFFFF, 0);
    add_item(KIND_POINT, 0, 32'sh80000000, 0);
    add_item(KIND_DIRECTION, 1, 0, 0);
    add_item(KIND_DIRECTION, 0, 0, -1);
    add_item(KIND_DIRECTION, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_item(KIND_DIRECTION, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_item(KIND_DIRECTION, 32'sh80000000, 32'sh7FFFFFFF, 1);
    add_item(KIND_POINT, 32'sh00010000, 32'sh00020000, 32'sh00030000);
    add_item(KIND_DIRECTION, 1, 32'sh7FFFFFFF, 0);
    add_item(KIND_DIRECTION, -1, 1, 1);
    drain();

    set_camera(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    add_item(KIND_POINT, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    add_item(KIND_POINT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    add_item(KIND_POINT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_item(KIND_POINT, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF);
    add_random_items(300);
    drain();

    set_camera($urandom, $urandom, $urandom);
    add_random_items(300);
    drain();

    set_camera(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_random_items(300);
    drain();

    set_camera($signed($urandom_range(0, 511)) - 256, 32'sh00010000, -5);
    add_random_items(330);
    drain();

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
